/* src/lpht_pkg.sv */
// shared types, constants and codes for the linear probe hash table
`timescale 1ns / 1ps
`default_nettype none

package lpht_pkg;

    localparam int TABLE_SIZE_DEF = 16;

    localparam int OP_W          = 1;
    localparam int KEY_W         = 31;
    localparam int VALUE_W       = 32;
    localparam int STATUS_W      = 3;
    localparam int SLOT_W        = 4;
    localparam int ENTRY_COUNT_W = 5;
    localparam int MARK_W        = 2;
    localparam int WORD_W        = MARK_W + KEY_W + VALUE_W;

    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

    localparam logic [MARK_W-1:0] MARK_EMPTY = 2'd0;
    localparam logic [MARK_W-1:0] MARK_USED  = 2'd1;
    localparam logic [MARK_W-1:0] MARK_TOMB  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISSING  = 3'd4;

    localparam int MOD_BITS_PER_STEP = 8;
    localparam int MOD_STEPS         = 4;
    localparam int MOD_STEP_W        = 2;
    localparam int KEY_PAD_W         = MOD_BITS_PER_STEP * MOD_STEPS;

    typedef struct packed {
        logic [OP_W-1:0]           op;
        logic [KEY_W-1:0]          key;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic [SLOT_W-1:0]        slot;
        logic [ENTRY_COUNT_W-1:0] entry_count;
    } out_item_t;

    typedef struct packed {
        logic clear;
        logic start;
        logic mod_step;
        logic prime;
        logic probe;
        logic finish;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic mod_last;
        logic stop;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

/* src/lpht_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

/* src/lpht_ctrl.sv */
// controller state machine for the linear probe hash table
`timescale 1ns / 1ps
`default_nettype none

module lpht_ctrl (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire lpht_pkg::dp_status_t   status,
    output lpht_pkg::ctrl_cmd_t         cmd
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HOME   = 3'd2;
    localparam logic [2:0] S_PRIME  = 3'd3;
    localparam logic [2:0] S_PROBE  = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_HOME;
                end
            end
            S_HOME:
            begin
                cmd.mod_step = 1'b1;
                if (status.mod_last)
                begin
                    state_next = S_PRIME;
                end
            end
            S_PRIME:
            begin
                cmd.prime  = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                cmd.probe = 1'b1;
                if (status.stop)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

/* src/lpht_dp.sv */
// datapath: home slot unit, probe counters, slot ram and output register
`timescale 1ns / 1ps
`default_nettype none

module lpht_dp #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire lpht_pkg::ctrl_cmd_t  cmd,
    input  wire lpht_pkg::in_item_t   in_data,
    input  wire logic                 out_ready,
    output logic                      out_valid,
    output lpht_pkg::out_item_t       out_data,
    output lpht_pkg::dp_status_t      status
);

    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int REM_W      = IDX_W + 1;
    localparam int CNT_W      = $clog2(TABLE_SIZE + 1);
    localparam int SLOT_EXT_W = (IDX_W > lpht_pkg::SLOT_W) ? IDX_W : lpht_pkg::SLOT_W;
    localparam int CNT_EXT_W  = (CNT_W > lpht_pkg::ENTRY_COUNT_W) ? CNT_W
                                                                  : lpht_pkg::ENTRY_COUNT_W;
    localparam int MB         = lpht_pkg::MOD_BITS_PER_STEP;
    localparam int KP         = lpht_pkg::KEY_PAD_W;
    localparam int KW         = lpht_pkg::KEY_W;
    localparam int VW         = lpht_pkg::VALUE_W;
    localparam int WW         = lpht_pkg::WORD_W;

    // item registers
    logic [lpht_pkg::OP_W-1:0] op_reg;
    logic [KW-1:0]             key_reg;
    logic [VW-1:0]             value_reg;

    // home slot unit
    logic [KP-1:0]                    key_shift_reg;
    logic [lpht_pkg::MOD_STEP_W-1:0]  mod_step_reg;
    logic [IDX_W-1:0]                 rem_reg;
    logic [IDX_W-1:0]                 rem_next;
    logic [REM_W-1:0]                 rem_acc;
    logic [MB-1:0]                    mod_bits;

    // probe state
    logic [IDX_W-1:0] clr_idx_reg;
    logic [IDX_W-1:0] eval_pos_reg;
    logic [IDX_W-1:0] next_pos;
    logic [IDX_W-1:0] probe_n_reg;
    logic             have_free_reg;
    logic [IDX_W-1:0] free_pos_reg;
    logic             cand_have;
    logic [IDX_W-1:0] cand_pos;
    logic             last_probe;

    // ram
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr;
    logic [WW-1:0]    ram_wdata;
    logic [IDX_W-1:0] ram_raddr;
    logic [WW-1:0]    ram_rdata;

    logic [lpht_pkg::MARK_W-1:0] rd_mark;
    logic [KW-1:0]               rd_key;
    logic                        rd_used;
    logic                        rd_empty;
    logic                        rd_hit;

    // evaluation outcome
    logic                          stop;
    logic [lpht_pkg::STATUS_W-1:0] ev_status;
    logic [IDX_W-1:0]              ev_slot;
    logic                          ev_we;
    logic [WW-1:0]                 ev_wdata;
    logic                          ev_inc;
    logic                          ev_dec;

    logic [lpht_pkg::STATUS_W-1:0] res_status_reg;
    logic [IDX_W-1:0]              res_slot_reg;
    logic                          res_we_reg;
    logic [WW-1:0]                 res_wdata_reg;
    logic                          res_inc_reg;
    logic                          res_dec_reg;

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [SLOT_EXT_W-1:0] slot_ext;
    logic [CNT_EXT_W-1:0]  count_ext;

    logic                  out_valid_reg;
    lpht_pkg::out_item_t   out_data_reg;

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg    <= in_data.op;
            key_reg   <= in_data.key;
            value_reg <= in_data.value;
        end
    end

    // key mod table size, one byte of the key per step, msb first
    assign mod_bits = key_shift_reg[KP-1 -: MB];

    always_comb
    begin
        rem_acc = {1'b0, rem_reg};
        for (int i = 0; i < MB; i++)
        begin
            rem_acc = {rem_acc[IDX_W-1:0], mod_bits[MB-1-i]};
            if (rem_acc >= REM_W'(TABLE_SIZE))
            begin
                rem_acc = rem_acc - REM_W'(TABLE_SIZE);
            end
        end
        rem_next = rem_acc[IDX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            key_shift_reg <= KP'(in_data.key);
            rem_reg       <= '0;
        end
        else if (cmd.mod_step)
        begin
            key_shift_reg <= key_shift_reg << MB;
            rem_reg       <= rem_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_step_reg <= '0;
        end
        else if (cmd.start)
        begin
            mod_step_reg <= '0;
        end
        else if (cmd.mod_step)
        begin
            mod_step_reg <= mod_step_reg + 1'b1;
        end
    end

    // clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_idx_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
        end
    end

    // probe walk
    assign next_pos   = (eval_pos_reg == IDX_W'(TABLE_SIZE - 1)) ? '0 : eval_pos_reg + 1'b1;
    assign last_probe = (probe_n_reg == IDX_W'(TABLE_SIZE - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eval_pos_reg  <= '0;
            probe_n_reg   <= '0;
            have_free_reg <= 1'b0;
            free_pos_reg  <= '0;
        end
        else if (cmd.prime)
        begin
            eval_pos_reg  <= rem_reg;
            probe_n_reg   <= '0;
            have_free_reg <= 1'b0;
            free_pos_reg  <= '0;
        end
        else if (cmd.probe)
        begin
            eval_pos_reg  <= next_pos;
            probe_n_reg   <= probe_n_reg + 1'b1;
            have_free_reg <= cand_have;
            free_pos_reg  <= cand_pos;
        end
    end

    assign ram_raddr = cmd.prime ? rem_reg : next_pos;
    assign ram_we    = cmd.clear | (cmd.finish & res_we_reg);
    assign ram_waddr = cmd.clear ? clr_idx_reg : res_slot_reg;
    assign ram_wdata = cmd.clear ? {lpht_pkg::MARK_EMPTY, {(WW - lpht_pkg::MARK_W){1'b0}}}
                                 : res_wdata_reg;

    lpht_ram #(
        .WIDTH (WW),
        .DEPTH (TABLE_SIZE)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_mark  = ram_rdata[WW-1 -: lpht_pkg::MARK_W];
    assign rd_key   = ram_rdata[VW +: KW];
    assign rd_used  = (rd_mark == lpht_pkg::MARK_USED);
    assign rd_empty = (rd_mark == lpht_pkg::MARK_EMPTY);
    assign rd_hit   = rd_used && (rd_key == key_reg);

    // empty slots, tombstones and unused codes count as free places for an insert
    assign cand_have = have_free_reg | ~rd_used;
    assign cand_pos  = have_free_reg ? free_pos_reg : eval_pos_reg;

    assign stop = rd_hit | rd_empty | last_probe;

    always_comb
    begin
        ev_status = lpht_pkg::ST_MISSING;
        ev_slot   = '0;
        ev_we     = 1'b0;
        ev_wdata  = {lpht_pkg::MARK_USED, key_reg, value_reg};
        ev_inc    = 1'b0;
        ev_dec    = 1'b0;
        if (op_reg == lpht_pkg::OP_INSERT)
        begin
            if (rd_hit)
            begin
                ev_status = lpht_pkg::ST_UPDATED;
                ev_slot   = eval_pos_reg;
                ev_we     = 1'b1;
            end
            else if (cand_have)
            begin
                ev_status = lpht_pkg::ST_INSERTED;
                ev_slot   = cand_pos;
                ev_we     = 1'b1;
                ev_inc    = 1'b1;
            end
            else
            begin
                ev_status = lpht_pkg::ST_FULL;
            end
        end
        else if (rd_hit)
        begin
            ev_status = lpht_pkg::ST_REMOVED;
            ev_slot   = eval_pos_reg;
            ev_we     = 1'b1;
            ev_wdata  = {lpht_pkg::MARK_TOMB, ram_rdata[WW-lpht_pkg::MARK_W-1:0]};
            ev_dec    = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.probe && stop)
        begin
            res_status_reg <= ev_status;
            res_slot_reg   <= ev_slot;
            res_wdata_reg  <= ev_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_we_reg  <= 1'b0;
            res_inc_reg <= 1'b0;
            res_dec_reg <= 1'b0;
        end
        else if (cmd.probe && stop)
        begin
            res_we_reg  <= ev_we;
            res_inc_reg <= ev_inc;
            res_dec_reg <= ev_dec;
        end
    end

    // entry count
    always_comb
    begin
        count_next = count_reg;
        if (res_inc_reg)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (res_dec_reg && (count_reg != '0))
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.finish)
        begin
            count_reg <= count_next;
        end
    end

    // output beat register
    assign slot_ext  = SLOT_EXT_W'(res_slot_reg);
    assign count_ext = CNT_EXT_W'(count_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_data_reg.status      <= res_status_reg;
            out_data_reg.slot        <= slot_ext[lpht_pkg::SLOT_W-1:0];
            out_data_reg.entry_count <= count_ext[lpht_pkg::ENTRY_COUNT_W-1:0];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.clear_last = (clr_idx_reg == IDX_W'(TABLE_SIZE - 1));
    assign status.mod_last   = (mod_step_reg ==
                                lpht_pkg::MOD_STEP_W'(lpht_pkg::MOD_STEPS - 1));
    assign status.stop       = stop;
    assign status.out_free   = ~out_valid_reg | out_ready;

endmodule

`default_nettype wire

/* src/linear_probe_hash_table_unit.sv */
// top level of the linear probe hash table
// result path: start, home slot steps, priming read, p probes (1 to TABLE_SIZE), then finish once output is free
// items are taken one at a time, the single read port walking the slot ram; in_ready is low until the finish
// home slot: one key byte per cycle through the modulo unit
// reset: asynchronous, then a clearing pass marks every slot empty
// with in_ready low; entry count resets to zero
`timescale 1ns / 1ps
`default_nettype none

module linear_probe_hash_table_unit #(
    parameter int TABLE_SIZE = lpht_pkg::TABLE_SIZE_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire lpht_pkg::in_item_t   in_data,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output lpht_pkg::out_item_t       out_data
);

    lpht_pkg::ctrl_cmd_t  cmd;
    lpht_pkg::dp_status_t status;

    lpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    lpht_dp #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .out_data  (out_data),
        .status    (status)
    );

endmodule

`default_nettype wire
